@@ hdl/svgp_pkg.sv @@
// shared constants and register codes for the spatial voice gain and pan block
// used by spatial_voice_gain_pan; depends on nothing
package svgp_pkg;

    localparam int COORD_WIDTH_DEF    = 24;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    localparam int FACING_W   = 14;
    localparam int ROLL_W     = 16;
    localparam int ROLL_SHIFT = 12;
    localparam int PAN_W      = 16;
    localparam int PAN_DEAD   = 4;
    localparam int POS_SHIFT  = 3;

    localparam logic signed [FACING_W-1:0] FACING_Z_RESET = -14'sd4096;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASTER_VOLUME  = 3'd0,
        REG_EFFECTS_VOLUME = 3'd1,
        REG_LISTENER_X     = 3'd2,
        REG_LISTENER_Y     = 3'd3,
        REG_LISTENER_Z     = 3'd4,
        REG_FACING_X       = 3'd5,
        REG_FACING_Z       = 3'd6,
        REG_MUTE           = 3'd7
    } cfg_reg_t;

endpackage

@@ hdl/svgp_isqrt.sv @@
// pipelined floor square root, one result bit per stage
// standalone; instantiated by spatial_voice_gain_pan
module svgp_isqrt #(
    parameter int RW = 25
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [2*RW-1:0] radicand,
    output logic [RW-1:0]   root
);

    localparam int RMW = RW + 2;

    logic [RMW-1:0]  rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [2*RW-1:0] val_reg  [RW];

    for (genvar g = 0; g < RW; g++) begin : g_st
        logic [RMW-1:0]  rem_i;
        logic [RW-1:0]   root_i;
        logic [2*RW-1:0] val_i;
        logic [RMW+1:0]  sh;
        logic [RMW+1:0]  trial;
        logic [RMW+1:0]  diff;
        logic            ge;

        if (g == 0) begin : g_first
            assign rem_i  = '0;
            assign root_i = '0;
            assign val_i  = radicand;
        end else begin : g_rest
            assign rem_i  = rem_reg[g-1];
            assign root_i = root_reg[g-1];
            assign val_i  = val_reg[g-1];
        end

        // bring down the next two radicand bits and try 4*root+1
        assign sh    = {rem_i, val_i[2*RW-1 -: 2]};
        assign trial = {2'b00, root_i, 2'b01};
        assign ge    = (sh >= trial);
        assign diff  = sh - trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= ge ? diff[RMW-1:0] : sh[RMW-1:0];
                root_reg[g] <= {root_i[RW-2:0], ge};
                val_reg[g]  <= {val_i[2*RW-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

@@ hdl/svgp_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// standalone; the caller guarantees the quotient fits in QB bits
module svgp_div #(
    parameter int NW = 39,
    parameter int DW = 30,
    parameter int QB = 17
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QB-1:0] quot
);

    logic [DW-1:0] rem_reg  [QB];
    logic [QB-1:0] low_reg  [QB];
    logic [DW-1:0] den_reg  [QB];
    logic [QB-1:0] quot_reg [QB];

    logic [NW-1:0] num_hi;

    assign num_hi = num >> QB;

    for (genvar g = 0; g < QB; g++) begin : g_st
        logic [DW-1:0] rem_i;
        logic [QB-1:0] low_i;
        logic [DW-1:0] den_i;
        logic [QB-1:0] quot_i;
        logic [DW:0]   sh;
        logic [DW:0]   diff;
        logic          ge;

        if (g == 0) begin : g_first
            assign rem_i  = num_hi[DW-1:0];
            assign low_i  = num[QB-1:0];
            assign den_i  = den;
            assign quot_i = '0;
        end else begin : g_rest
            assign rem_i  = rem_reg[g-1];
            assign low_i  = low_reg[g-1];
            assign den_i  = den_reg[g-1];
            assign quot_i = quot_reg[g-1];
        end

        assign sh   = {rem_i, low_i[QB-1]};
        assign ge   = (sh >= {1'b0, den_i});
        assign diff = sh - {1'b0, den_i};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g]  <= ge ? diff[DW-1:0] : sh[DW-1:0];
                low_reg[g]  <= {low_i[QB-2:0], 1'b0};
                den_reg[g]  <= den_i;
                quot_reg[g] <= {quot_i[QB-2:0], ge};
            end
        end
    end

    assign quot = quot_reg[QB-1];

endmodule

@@ hdl/spatial_voice_gain_pan.sv @@
// top level: per-voice distance attenuation and stereo pan gains
// depends on svgp_pkg, svgp_isqrt and svgp_div
//
// Each item on the s_ channel carries one voice's position, near and far
// distances, rolloff, volume and fixed pan; s_tuser flags a spatial voice.
// Each item gives exactly one result item on the m_ channel: left gain,
// right gain and the pan that was applied. Listener position, facing,
// master and effects volumes and mute sit in registers on the cfg_ port;
// the user must write them only while no item is in flight, as the block
// itself does not enforce this. From accept to m_tvalid an item passes
// stages 1 to 3, the square root units, stages 4 and 5, the dividers,
// stage 6 and the output register.
// Throughput is one item per cycle while the receiver does not stall; the
// root and divider units are fully pipelined.
// Reset clears all valid bits and loads the register defaults: unity
// volumes, listener at the origin facing -z, mute off.
// When the receiver stalls the whole pipeline holds, and s_tready drops
// only while a result waits in the output register and m_tready is low.
module spatial_voice_gain_pan #(
    parameter  int COORD_WIDTH    = svgp_pkg::COORD_WIDTH_DEF,
    parameter  int GAIN_FRAC_BITS = svgp_pkg::GAIN_FRAC_BITS_DEF,
    localparam int VW      = GAIN_FRAC_BITS + 1,
    localparam int IN_BITS = 5 * COORD_WIDTH - 2 + svgp_pkg::ROLL_W + VW + svgp_pkg::PAN_W,
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 2 * VW + svgp_pkg::PAN_W,
    localparam int OUT_W   = ((OUT_BITS + 7) / 8) * 8,
    localparam int CFG_W   = (COORD_WIDTH > VW) ? COORD_WIDTH : VW
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // source_x, source_y, source_z, near_distance, far_distance, rolloff,
    // voice_level, fixed_pan, zero fill
    input  logic [IN_W-1:0]                s_tdata,
    // spatial
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // left_mix, right_mix, pan_used, zero fill
    output logic [OUT_W-1:0]               m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [svgp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]               cfg_wr_data
);

    localparam int CW    = COORD_WIDTH;
    localparam int GF    = GAIN_FRAC_BITS;
    localparam int FW    = svgp_pkg::FACING_W;
    localparam int RLW   = svgp_pkg::ROLL_W;
    localparam int PW    = svgp_pkg::PAN_W;
    localparam int DXW   = CW + 1;
    localparam int RW    = CW + 1;
    localparam int RXW   = FW + 1;
    localparam int PRW   = DXW + RXW;
    localparam int DOTW  = PRW + 1;
    localparam int MAGW  = DOTW + svgp_pkg::POS_SHIFT;
    localparam int RPW   = RLW + RW;
    localparam int GDW   = RPW - svgp_pkg::ROLL_SHIFT + 1;
    localparam int GNW   = CW - 1 + GF;
    localparam int PQMIN = PW + 1;
    localparam int QB    = (VW > PQMIN) ? VW : PQMIN;
    localparam int SATW  = MAGW + RW + QB;

    localparam logic [VW-1:0]   UNITY    = {1'b1, {GF{1'b0}}};
    localparam logic [PW+1:0]   PAN_ONE  = {2'b01, {PW{1'b0}}};
    localparam logic [PW-1:0]   PAN_MAXP = {1'b0, {(PW-1){1'b1}}};
    localparam logic [PW-1:0]   PAN_MAXN = {1'b1, {(PW-1){1'b0}}};

    // configuration registers
    logic [VW-1:0]        master_reg;
    logic [VW-1:0]        effects_reg;
    logic signed [CW-1:0] lx_reg, ly_reg, lz_reg;
    logic signed [FW-1:0] fx_reg, fz_reg;
    logic                 mute_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_reg  <= UNITY;
            effects_reg <= UNITY;
            lx_reg      <= '0;
            ly_reg      <= '0;
            lz_reg      <= '0;
            fx_reg      <= '0;
            fz_reg      <= svgp_pkg::FACING_Z_RESET;
            mute_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                svgp_pkg::REG_MASTER_VOLUME:  master_reg  <= cfg_wr_data[VW-1:0];
                svgp_pkg::REG_EFFECTS_VOLUME: effects_reg <= cfg_wr_data[VW-1:0];
                svgp_pkg::REG_LISTENER_X:     lx_reg      <= cfg_wr_data[CW-1:0];
                svgp_pkg::REG_LISTENER_Y:     ly_reg      <= cfg_wr_data[CW-1:0];
                svgp_pkg::REG_LISTENER_Z:     lz_reg      <= cfg_wr_data[CW-1:0];
                svgp_pkg::REG_FACING_X:       fx_reg      <= cfg_wr_data[FW-1:0];
                svgp_pkg::REG_FACING_Z:       fz_reg      <= cfg_wr_data[FW-1:0];
                svgp_pkg::REG_MUTE:           mute_reg    <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    logic [VW-1:0] master_sat, effects_sat;
    assign master_sat  = (master_reg > UNITY) ? UNITY : master_reg;
    assign effects_sat = (effects_reg > UNITY) ? UNITY : effects_reg;

    // right vector is (-facing_z, facing_x)
    logic signed [RXW-1:0] rx, rz;
    assign rx = -{fz_reg[FW-1], fz_reg};
    assign rz = {fx_reg[FW-1], fx_reg};

    // pipeline advance
    logic en;
    logic m_tvalid_reg;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // stage 1: unpack, offsets from listener
    typedef struct packed {
        logic                  valid;
        logic signed [DXW-1:0] dx;
        logic signed [DXW-1:0] dy;
        logic signed [DXW-1:0] dz;
        logic [CW-2:0]         near_d;
        logic [CW-2:0]         far_d;
        logic [RLW-1:0]        roll;
        logic [VW-1:0]         vol;
        logic [PW-1:0]         fpan;
        logic                  spatial;
    } s1_t;

    localparam int O_SY   = CW;
    localparam int O_SZ   = 2 * CW;
    localparam int O_NEAR = 3 * CW;
    localparam int O_FAR  = 4 * CW - 1;
    localparam int O_ROLL = 5 * CW - 2;
    localparam int O_VOL  = O_ROLL + RLW;
    localparam int O_PAN  = O_VOL + VW;

    s1_t s1_reg, s1_next;
    logic signed [CW-1:0] sx, sy, sz;
    logic [VW-1:0]        vin;

    always_comb begin
        sx = s_tdata[0 +: CW];
        sy = s_tdata[O_SY +: CW];
        sz = s_tdata[O_SZ +: CW];
        vin = s_tdata[O_VOL +: VW];
        s1_next.valid   = s_tvalid;
        s1_next.dx      = {sx[CW-1], sx} - {lx_reg[CW-1], lx_reg};
        s1_next.dy      = {sy[CW-1], sy} - {ly_reg[CW-1], ly_reg};
        s1_next.dz      = {sz[CW-1], sz} - {lz_reg[CW-1], lz_reg};
        s1_next.near_d  = s_tdata[O_NEAR +: CW-1];
        s1_next.far_d   = s_tdata[O_FAR +: CW-1];
        s1_next.roll    = s_tdata[O_ROLL +: RLW];
        s1_next.vol     = (vin > UNITY) ? UNITY : vin;
        s1_next.fpan    = s_tdata[O_PAN +: PW];
        s1_next.spatial = s_tuser[0];
    end

    // stage 2: squares, dot terms, first volume product
    typedef struct packed {
        logic                  valid;
        logic [2*RW-1:0]       sqx;
        logic [2*RW-1:0]       sqy;
        logic [2*RW-1:0]       sqz;
        logic signed [PRW-1:0] dota;
        logic signed [PRW-1:0] dotb;
        logic [CW-2:0]         near_d;
        logic [CW-2:0]         far_d;
        logic [RLW-1:0]        roll;
        logic [VW-1:0]         vol;
        logic [PW-1:0]         fpan;
        logic                  spatial;
    } s2_t;

    s2_t s2_reg, s2_next;
    logic signed [2*DXW-1:0] px, py, pz;
    logic [2*VW-1:0]         v1;

    always_comb begin
        px = s1_reg.dx * s1_reg.dx;
        py = s1_reg.dy * s1_reg.dy;
        pz = s1_reg.dz * s1_reg.dz;
        v1 = s1_reg.vol * master_sat;
        s2_next.valid   = s1_reg.valid;
        s2_next.sqx     = px[2*RW-1:0];
        s2_next.sqy     = py[2*RW-1:0];
        s2_next.sqz     = pz[2*RW-1:0];
        s2_next.dota    = s1_reg.dx * rx;
        s2_next.dotb    = s1_reg.dz * rz;
        s2_next.near_d  = s1_reg.near_d;
        s2_next.far_d   = s1_reg.far_d;
        s2_next.roll    = s1_reg.roll;
        s2_next.vol     = v1[GF +: VW];
        s2_next.fpan    = s1_reg.fpan;
        s2_next.spatial = s1_reg.spatial;
    end

    // stage 3: sums, second volume product
    typedef struct packed {
        logic                   valid;
        logic signed [DOTW-1:0] dot;
        logic [CW-2:0]          near_d;
        logic [CW-2:0]          far_d;
        logic [RLW-1:0]         roll;
        logic [VW-1:0]          vol;
        logic [PW-1:0]          fpan;
        logic                   spatial;
    } sa_t;

    sa_t             s3_reg, s3_next;
    logic [2*RW-1:0] sum3_reg, sum3_next;
    logic [2*RW-1:0] sumh_reg, sumh_next;
    logic [2*VW-1:0] v2;

    always_comb begin
        v2 = s2_reg.vol * effects_sat;
        sum3_next = s2_reg.sqx + s2_reg.sqy + s2_reg.sqz;
        sumh_next = s2_reg.sqx + s2_reg.sqz;
        s3_next.valid   = s2_reg.valid;
        s3_next.dot     = {s2_reg.dota[PRW-1], s2_reg.dota}
                        + {s2_reg.dotb[PRW-1], s2_reg.dotb};
        s3_next.near_d  = s2_reg.near_d;
        s3_next.far_d   = s2_reg.far_d;
        s3_next.roll    = s2_reg.roll;
        s3_next.vol     = v2[GF +: VW];
        s3_next.fpan    = s2_reg.fpan;
        s3_next.spatial = s2_reg.spatial;
    end

    // square roots, sideband follows through a matching delay line
    logic [RW-1:0] src_dist, hdist;

    svgp_isqrt #(.RW(RW)) u_root3 (
        .aclk     (aclk),
        .en       (en),
        .radicand (sum3_reg),
        .root     (src_dist)
    );

    svgp_isqrt #(.RW(RW)) u_rooth (
        .aclk     (aclk),
        .en       (en),
        .radicand (sumh_reg),
        .root     (hdist)
    );

    sa_t sa_reg [RW];
    sa_t sa_out;
    assign sa_out = sa_reg[RW-1];

    // stage 4: range checks, rolloff product, pan magnitude
    typedef struct packed {
        logic              valid;
        logic              near_hit;
        logic              far_hit;
        logic [CW-2:0]     near_d;
        logic [RPW-1:0]    prod;
        logic [MAGW-1:0]   mag;
        logic [RW-1:0]     hdist;
        logic              neg;
        logic              dead;
        logic              sat;
        logic [VW-1:0]     vol;
        logic [PW-1:0]     fpan;
        logic              spatial;
    } s4_t;

    s4_t s4_reg, s4_next;
    logic [RW-1:0]   diff;
    logic [DOTW-1:0] mag_abs;

    always_comb begin
        diff    = src_dist - RW'(sa_out.near_d);
        mag_abs = sa_out.dot[DOTW-1] ? DOTW'(-sa_out.dot) : DOTW'(sa_out.dot);
        s4_next.valid    = sa_out.valid;
        s4_next.near_hit = (src_dist <= RW'(sa_out.near_d));
        s4_next.far_hit  = (src_dist >= RW'(sa_out.far_d));
        s4_next.near_d   = sa_out.near_d;
        s4_next.prod     = sa_out.roll * diff;
        s4_next.mag      = {mag_abs, {svgp_pkg::POS_SHIFT{1'b0}}};
        s4_next.hdist    = hdist;
        s4_next.neg      = sa_out.dot[DOTW-1];
        s4_next.dead     = (hdist < RW'(svgp_pkg::PAN_DEAD));
        // quotient would not fit the divider: saturate
        s4_next.sat      = (SATW'({mag_abs, {svgp_pkg::POS_SHIFT{1'b0}}})
                            >= SATW'({hdist, {QB{1'b0}}}));
        s4_next.vol      = sa_out.vol;
        s4_next.fpan     = sa_out.fpan;
        s4_next.spatial  = sa_out.spatial;
    end

    // stage 5: attenuation divisor
    s4_t            s5_reg;
    logic [GDW-1:0] d_reg, d_next;

    assign d_next = GDW'(s4_reg.near_d) + GDW'(s4_reg.prod[RPW-1:svgp_pkg::ROLL_SHIFT]);

    // dividers, sideband delay line alongside
    typedef struct packed {
        logic          valid;
        logic          near_hit;
        logic          far_hit;
        logic          d_zero;
        logic          neg;
        logic          dead;
        logic          sat;
        logic [VW-1:0] vol;
        logic [PW-1:0] fpan;
        logic          spatial;
    } sb_t;

    sb_t sb_next;
    sb_t sb_reg [QB];
    sb_t sb_out;
    logic [QB-1:0] gain_q, pan_q;

    always_comb begin
        sb_next.valid    = s5_reg.valid;
        sb_next.near_hit = s5_reg.near_hit;
        sb_next.far_hit  = s5_reg.far_hit;
        sb_next.d_zero   = (d_reg == '0);
        sb_next.neg      = s5_reg.neg;
        sb_next.dead     = s5_reg.dead;
        sb_next.sat      = s5_reg.sat;
        sb_next.vol      = s5_reg.vol;
        sb_next.fpan     = s5_reg.fpan;
        sb_next.spatial  = s5_reg.spatial;
    end

    svgp_div #(.NW(GNW), .DW(GDW), .QB(QB)) u_gain_div (
        .aclk (aclk),
        .en   (en),
        .num  ({s5_reg.near_d, {GF{1'b0}}}),
        .den  (d_reg),
        .quot (gain_q)
    );

    svgp_div #(.NW(MAGW), .DW(RW), .QB(QB)) u_pan_div (
        .aclk (aclk),
        .en   (en),
        .num  (s5_reg.mag),
        .den  (s5_reg.hdist),
        .quot (pan_q)
    );

    assign sb_out = sb_reg[QB-1];

    // stage 6: distance gain applied, pan saturated
    logic                 s6_valid_reg;
    logic [VW-1:0]        vol3_reg, vol3_next;
    logic signed [PW-1:0] pan6_reg, pan6_next;
    logic [VW-1:0]        gain_sel, gain_eff;
    logic [2*VW-1:0]      v3;
    logic [PW-1:0]        span;
    logic [PW:0]          pan_neg;

    always_comb begin
        if (sb_out.near_hit) begin
            gain_sel = UNITY;
        end else if (sb_out.far_hit || sb_out.d_zero) begin
            gain_sel = '0;
        end else begin
            gain_sel = gain_q[VW-1:0];
        end
        gain_eff = sb_out.spatial ? gain_sel : UNITY;
        v3       = sb_out.vol * gain_eff;
        vol3_next = v3[GF +: VW];

        pan_neg = -pan_q[PW:0];
        if (sb_out.neg) begin
            span = (sb_out.sat || pan_q > QB'(PAN_MAXN)) ? PAN_MAXN : pan_neg[PW-1:0];
        end else begin
            span = (sb_out.sat || pan_q > QB'(PAN_MAXP)) ? PAN_MAXP : pan_q[PW-1:0];
        end

        if (!sb_out.spatial) begin
            pan6_next = sb_out.fpan;
        end else if (sb_out.dead) begin
            pan6_next = '0;
        end else begin
            pan6_next = span;
        end
    end

    // stage 7: side gains into the output register
    logic [VW-1:0]        left_reg, left_next;
    logic [VW-1:0]        right_reg, right_next;
    logic signed [PW-1:0] pan_reg, pan_next;
    logic [PW+1:0]        lmul, rmul;
    logic [VW+PW+1:0]     lprod, rprod;

    always_comb begin
        lmul  = PAN_ONE - {{2{pan6_reg[PW-1]}}, pan6_reg};
        rmul  = PAN_ONE + {{2{pan6_reg[PW-1]}}, pan6_reg};
        lprod = vol3_reg * lmul;
        rprod = vol3_reg * rmul;
        if (mute_reg) begin
            left_next  = '0;
            right_next = '0;
            pan_next   = '0;
        end else begin
            left_next  = lprod[PW +: VW];
            right_next = rprod[PW +: VW];
            pan_next   = pan6_reg;
        end
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg       <= '0;
            s2_reg       <= '0;
            s3_reg       <= '0;
            s4_reg       <= '0;
            s5_reg       <= '0;
            s6_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < RW; i++) begin
                sa_reg[i] <= '0;
            end
            for (int i = 0; i < QB; i++) begin
                sb_reg[i] <= '0;
            end
        end else if (en) begin
            s1_reg       <= s1_next;
            s2_reg       <= s2_next;
            s3_reg       <= s3_next;
            sa_reg[0]    <= s3_reg;
            for (int i = 1; i < RW; i++) begin
                sa_reg[i] <= sa_reg[i-1];
            end
            s4_reg       <= s4_next;
            s5_reg       <= s4_reg;
            sb_reg[0]    <= sb_next;
            for (int i = 1; i < QB; i++) begin
                sb_reg[i] <= sb_reg[i-1];
            end
            s6_valid_reg <= sb_out.valid;
            m_tvalid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum3_reg  <= sum3_next;
            sumh_reg  <= sumh_next;
            d_reg     <= d_next;
            vol3_reg  <= vol3_next;
            pan6_reg  <= pan6_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            pan_reg   <= pan_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({pan_reg, right_reg, left_reg});

    // muted results carry nothing
    a_mute_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && mute_reg |-> left_reg == '0 && right_reg == '0 && pan_reg == '0)
        else $error("muted item has nonzero gain or pan");

    // side gain never exceeds one and a half times unity
    a_gain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> left_reg <= (UNITY + (UNITY >> 1))
                      && right_reg <= (UNITY + (UNITY >> 1)))
        else $error("side gain above bound");

    // centered pan splits volume evenly
    a_center_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !mute_reg && pan_reg == '0 |-> left_reg == right_reg)
        else $error("centered item has unequal gains");

endmodule
